// ===== design/mrlc_pkg.sv =====
// Package: widths, constants and types shared by the measure range line clip block.
package mrlc_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_FROM = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_TO = 1'b1;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_END,
      ST_EMIT_START,
      ST_EMIT_END
   } back_state_type;

endpackage

// ===== design/mrlc_if.sv =====
// Valid/ready channel interface carrying a parameterized payload.
interface mrlc_if #(parameter int PAYLOAD_WIDTH = 8);
   logic                     valid;
   logic                     ready;
   logic [PAYLOAD_WIDTH-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/mrlc_muldiv.sv =====
// Sequential unit: round(a * b / d), one quotient bit per cycle.
module mrlc_muldiv #(
   parameter int W = 33
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] d,
   output logic         done,
   output logic [W-1:0] quot
);
   localparam int PW = 2 * W;
   localparam int CW = $clog2(PW + 1);

   logic [PW-1:0] num_ff, num_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W-1:0]  mb_ff, mb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          mul_ff, mul_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    twice_rem;

   // Shift-add multiply, then restoring divide, both bit-serial
   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      den_in = den_ff;
      mb_in = mb_ff;
      cnt_in = cnt_ff;
      mul_in = mul_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[W-1:0], num_ff[PW-1]};
      twice_rem = {rem_ff[W-1:0], 1'b0};
      if (start) begin
         num_in = '0;
         rem_in = {1'b0, a};
         mb_in = b;
         den_in = d;
         quot_in = '0;
         cnt_in = CW'(W);
         mul_in = 1'b1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mul_ff) begin
            num_in = {num_ff[PW-2:0], 1'b0}
               + (mb_ff[W-1] ? {{W{1'b0}}, rem_ff[W-1:0]} : '0);
            mb_in = {mb_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               mul_in = 1'b0;
               rem_in = '0;
               cnt_in = CW'(PW);
            end
         end else if (cnt_ff != '0) begin
            num_in = {num_ff[PW-2:0], 1'b0};
            if (shifted >= {1'b0, den_ff}) begin
               rem_in = shifted - {1'b0, den_ff};
               quot_in = {quot_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quot_in = {quot_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            if (twice_rem >= {1'b0, den_ff}) quot_in = quot_ff + 1'b1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      den_ff <= den_in;
      mb_ff <= mb_in;
      cnt_ff <= cnt_in;
      mul_ff <= mul_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ===== design/mrlc_front.sv =====
// Front end: takes vertices, tracks string state and classifies each segment.
module mrlc_front #(
   parameter int VW = mrlc_pkg::VALUE_WIDTH_DEFAULT,
   parameter int JW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [VW-1:0] vx,
   input  logic [VW-1:0] vy,
   input  logic [VW-1:0] vm,
   input  logic          first_vertex,
   input  logic          last_vertex,
   input  logic [VW-1:0] range_from,
   input  logic [VW-1:0] range_to,
   output logic          job_valid,
   input  logic          job_ready,
   output logic [JW-1:0] job
);
   logic [VW-1:0] px_ff, py_ff, pm_ff;
   logic          have_ff, have_in, open_ff, open_in;
   logic          have_eff, open_eff;
   logic [VW-1:0] lo, hi;
   logic          k1l, k1h, k2l, k2h, miss, in1, in2, emit_s, endc, endflag;
   logic [VW-1:0] r1, r2;
   logic          take;

   assign in_ready = job_ready;
   assign take = in_valid && in_ready;

   // Order the bounds and classify the segment against them
   always_comb begin
      have_eff = have_ff && !first_vertex;
      open_eff = open_ff && !first_vertex;
      if ($signed(range_from) <= $signed(range_to)) begin
         lo = range_from;
         hi = range_to;
      end else begin
         lo = range_to;
         hi = range_from;
      end
      k1l = $signed(pm_ff) < $signed(lo);
      k1h = $signed(pm_ff) > $signed(hi);
      k2l = $signed(vm) < $signed(lo);
      k2h = $signed(vm) > $signed(hi);
      miss = (k1l && k2l) || (k1h && k2h);
      in1 = !k1l && !k1h;
      in2 = !k2l && !k2h;
      r1 = k1l ? lo : hi;
      r2 = k2h ? hi : lo;
      emit_s = !open_eff || !in1;
      endc = !in2;
      endflag = endc || last_vertex;
      job_valid = in_valid && have_eff && !miss;
      have_in = have_ff;
      open_in = open_ff;
      if (take) begin
         have_in = !last_vertex;
         if (!have_eff || miss || last_vertex) open_in = 1'b0;
         else open_in = !endflag;
      end
   end

   assign job = {px_ff, py_ff, pm_ff, vx, vy, vm, r1, r2, !in1, !in2, emit_s, endflag};

   always_ff @(posedge clock) begin
      if (take) begin
         px_ff <= vx;
         py_ff <= vy;
         pm_ff <= vm;
      end
      if (reset) begin
         have_ff <= 1'b0;
         open_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
         open_ff <= open_in;
      end
   end
endmodule

// ===== design/mrlc_queue.sv =====
// Short FIFO between front and back ends.
module mrlc_queue #(
   parameter int W = 8,
   parameter int DEPTH = mrlc_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  logic [W-1:0] wr_data,
   output logic         rd_valid,
   input  logic         rd_ready,
   output logic [W-1:0] rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [CW-1:0] cnt_ff;
   logic          wr, rd;

   assign wr_ready = cnt_ff != CW'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + CW'(wr) - CW'(rd);
      end
   end
endmodule

// ===== design/mrlc_back.sv =====
// Back end: interpolates clipped points with a shared divider and emits them.
module mrlc_back #(
   parameter int VW = mrlc_pkg::VALUE_WIDTH_DEFAULT,
   parameter int JW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   output logic          job_ready,
   input  logic [JW-1:0] job,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [VW-1:0] out_x,
   output logic [VW-1:0] out_y,
   output logic          piece_end,
   output logic          run_last
);
   localparam int DW = VW + 1;

   mrlc_pkg::back_state_type state_ff, state_in;
   logic [VW-1:0] x1, y1, m1, x2, y2, m2, r1, r2;
   logic          c1, c2, emit_s, endflag;
   logic [JW-1:0] job_ff;
   logic [VW-1:0] sx_ff, sy_ff, ex_ff, ey_ff, sx_in, sy_in, ex_in, ey_in;
   logic          axis_ff, axis_in;
   logic          go;
   logic [DW-1:0] dm, t1, t2, dx, dy, da, dbv;
   logic          nx, ny;
   logic          dv_start, dv_done;
   logic [DW-1:0] dv_q;
   logic [VW-1:0] base, lerp_val;
   logic          lerp_neg;
   logic          ov_ff, ov_in, pe_ff, pe_in, rl_ff, rl_in;
   logic [VW-1:0] ox_ff, oy_ff, ox_in, oy_in;
   logic          out_free;
   logic          kick_ff;
   logic          dv_go;

   assign {x1, y1, m1, x2, y2, m2, r1, r2, c1, c2, emit_s, endflag} = job_ff;

   // Magnitudes of differences, sign-extended one bit
   function automatic logic [DW-1:0] mag(input logic [VW-1:0] a, input logic [VW-1:0] b);
      logic [DW-1:0] d;
      d = {b[VW-1], b} - {a[VW-1], a};
      return d[DW-1] ? (~d + 1'b1) : d;
   endfunction

   assign dm = mag(m1, m2);
   assign t1 = mag(m1, r1);
   assign t2 = mag(m1, r2);
   assign dx = mag(x1, x2);
   assign dy = mag(y1, y2);
   assign nx = $signed(x2) < $signed(x1);
   assign ny = $signed(y2) < $signed(y1);

   // Operand select for the pass being started: next axis and next state
   assign da = axis_in ? dy : dx;
   assign dbv = (state_in == mrlc_pkg::ST_DIV_START) ? t1 : t2;
   // Result of the finished pass: current axis
   assign base = axis_ff ? y1 : x1;
   assign lerp_neg = axis_ff ? ny : nx;
   assign lerp_val = lerp_neg ? base - dv_q[VW-1:0] : base + dv_q[VW-1:0];

   mrlc_muldiv #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(dv_go),
      .a(da), .b(dbv), .d(dm), .done(dv_done), .quot(dv_q)
   );

   assign out_free = !ov_ff || out_ready;
   assign job_ready = state_ff == mrlc_pkg::ST_IDLE;
   assign go = job_valid && job_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrlc_pkg::ST_IDLE:
            if (go) state_in = mrlc_pkg::ST_DIV_START;
         mrlc_pkg::ST_DIV_START:
            if (!c1 || (dv_done && axis_ff)) state_in = mrlc_pkg::ST_DIV_END;
         mrlc_pkg::ST_DIV_END:
            if (!c2 || (dv_done && axis_ff))
               state_in = emit_s ? mrlc_pkg::ST_EMIT_START : mrlc_pkg::ST_EMIT_END;
         mrlc_pkg::ST_EMIT_START:
            if (out_free) state_in = mrlc_pkg::ST_EMIT_END;
         mrlc_pkg::ST_EMIT_END:
            if (out_free) state_in = mrlc_pkg::ST_IDLE;
         default: state_in = mrlc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register control
   always_comb begin
      sx_in = sx_ff; sy_in = sy_ff; ex_in = ex_ff; ey_in = ey_ff;
      axis_in = axis_ff;
      dv_start = 1'b0;
      ov_in = ov_ff && !out_ready;
      ox_in = ox_ff; oy_in = oy_ff; pe_in = pe_ff; rl_in = rl_ff;
      unique case (state_ff)
         mrlc_pkg::ST_IDLE: begin
            axis_in = 1'b0;
         end
         mrlc_pkg::ST_DIV_START: begin
            if (!c1) begin
               sx_in = x1; sy_in = y1;
               dv_start = c2;
            end else if (dv_done) begin
               if (axis_ff) sy_in = lerp_val; else sx_in = lerp_val;
               axis_in = !axis_ff;
               dv_start = !axis_ff || c2;
            end
         end
         mrlc_pkg::ST_DIV_END: begin
            if (!c2) begin
               ex_in = x2; ey_in = y2;
            end else if (dv_done) begin
               if (axis_ff) ey_in = lerp_val; else ex_in = lerp_val;
               axis_in = !axis_ff;
               dv_start = !axis_ff;
            end
         end
         mrlc_pkg::ST_EMIT_START: begin
            if (out_free) begin
               ov_in = 1'b1; ox_in = sx_ff; oy_in = sy_ff; pe_in = 1'b0; rl_in = 1'b0;
            end
         end
         mrlc_pkg::ST_EMIT_END: begin
            if (out_free) begin
               ov_in = 1'b1; ox_in = ex_ff; oy_in = ey_ff; pe_in = endflag; rl_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // State and datapath registers; the job-entry kick starts the first division when the start is clipped
   always_ff @(posedge clock) begin
      if (go) job_ff <= job;
      sx_ff <= sx_in; sy_ff <= sy_in; ex_ff <= ex_in; ey_ff <= ey_in;
      ox_ff <= ox_in; oy_ff <= oy_in; pe_ff <= pe_in; rl_ff <= rl_in;
      if (reset) begin
         state_ff <= mrlc_pkg::ST_IDLE;
         axis_ff <= 1'b0;
         ov_ff <= 1'b0;
         kick_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         ov_ff <= ov_in;
         kick_ff <= go;
      end
   end

   // Divider start: on job entry when the start is clipped, else as sequenced
   assign dv_go = (kick_ff && c1) || dv_start;

   assign out_valid = ov_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign piece_end = pe_ff;
   assign run_last = rl_ff;
endmodule

// ===== design/measure_range_line_clip.sv =====
// Measure range line clip: clips measured line strings to a measure range.
// Each job passes through the queue and the back-end states DIV_START, DIV_END and the emit
// states; each clipped point adds two bit-serial mul/div passes, one per axis.
// The back end takes a new job only in its idle state, so throughput is set by
// the single shared multiply-divide unit; a two-entry queue decouples the front end.
// Reset (synchronous, active high) clears string state, range registers and queue.
module measure_range_line_clip #(
   parameter int VALUE_WIDTH = mrlc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mrlc_if.sink   req,
   mrlc_if.source rsp,
   input  logic                                 csr_we,
   input  logic [mrlc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mrlc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   localparam int JW = 8 * VALUE_WIDTH + 4;

   logic [VALUE_WIDTH-1:0] range_from_ff, range_to_ff;
   logic [VALUE_WIDTH-1:0] req_vx, req_vy, req_vm;
   logic                   req_first_vertex, req_last_vertex;
   logic                   fj_valid, fj_ready, bj_valid, bj_ready;
   logic [JW-1:0]          fj, bj;

   assign {req_vx, req_vy, req_vm, req_first_vertex, req_last_vertex} = req.payload;

   // Range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_from_ff <= '0;
         range_to_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            mrlc_pkg::CSR_RANGE_FROM: range_from_ff <= VALUE_WIDTH'(signed'(csr_wdata));
            mrlc_pkg::CSR_RANGE_TO:   range_to_ff <= VALUE_WIDTH'(signed'(csr_wdata));
            default: ;
         endcase
      end
   end

   mrlc_front #(.VW(VALUE_WIDTH), .JW(JW)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .vx(req_vx), .vy(req_vy), .vm(req_vm),
      .first_vertex(req_first_vertex), .last_vertex(req_last_vertex),
      .range_from(range_from_ff), .range_to(range_to_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   mrlc_queue #(.W(JW)) u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
   );

   logic [VALUE_WIDTH-1:0] rsp_out_x, rsp_out_y;
   logic                   rsp_piece_end, rsp_run_last;

   mrlc_back #(.VW(VALUE_WIDTH), .JW(JW)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_x(rsp_out_x), .out_y(rsp_out_y),
      .piece_end(rsp_piece_end), .run_last(rsp_run_last)
   );

   assign rsp.payload = {rsp_out_x, rsp_out_y, rsp_piece_end, rsp_run_last};

   // A closed piece is always the last result of its vertex
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp_piece_end |-> rsp_run_last)
      else $error("piece_end without run_last");

   // Configuration holds while the back end works is not required; range resets to zero
   assert property (@(posedge clock) $past(reset) |-> range_from_ff == '0 && range_to_ff == '0)
      else $error("range registers not cleared");

   // An idle back end with an empty queue raises no new output
   assert property (@(posedge clock) disable iff (reset) bj_ready && !bj_valid |=> !rsp.valid || $past(rsp.valid))
      else $error("back end output without job");
endmodule

// ===== bench/testbench.sv =====
// Testbench for the measure range line clip block: predicts clipped points and checks them.
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vm;
      logic               first_vertex;
      logic               last_vertex;
   } vertex_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               piece_end;
      logic               run_last;
   } point_type;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 500;
   localparam longint INT_MIN = -64'sd2147483648;
   localparam longint INT_MAX = 64'sd2147483647;

   // Clip predictor and store of expected points
   class clip_scoreboard;
      longint range_from, range_to;
      longint prev_x, prev_y, prev_m;
      bit have_prev, piece_open;
      point_type expected_points[$];
      int errors;

      function new();
         range_from = 0; range_to = 0;
         prev_x = 0; prev_y = 0; prev_m = 0;
         have_prev = 0; piece_open = 0;
         errors = 0;
      endfunction

      function void report(string what);
         $display("mismatch: %s", what);
         errors++;
      endfunction

      // round(mag * t / dm) from a1, ties away from a1
      function longint interpolate(longint a1, longint a2, longint t, longint dm);
         logic [127:0] prod, quo, rem;
         longint mag;
         bit neg;
         neg = a2 < a1;
         mag = neg ? a1 - a2 : a2 - a1;
         prod = 128'(mag) * 128'(t);
         quo = prod / 128'(dm);
         rem = prod % 128'(dm);
         if (rem >= 128'(dm) - rem) quo++;
         return longint'($signed(32'(neg ? a1 - longint'(quo) : a1 + longint'(quo))));
      endfunction

      function void push_point(longint x, longint y, bit pend);
         point_type p;
         p.out_x = 32'(x);
         p.out_y = 32'(y);
         p.piece_end = pend;
         p.run_last = 0;
         expected_points.push_back(p);
      endfunction

      function void note_vertex(vertex_type v);
         longint x2, y2, m2, lo, hi, sx, sy, ex, ey, dm;
         bit in1, in2, endc, pend;
         int n0;
         x2 = v.vx; y2 = v.vy; m2 = v.vm;
         n0 = expected_points.size();
         if (v.first_vertex) begin
            have_prev = 0;
            piece_open = 0;
         end
         if (have_prev) begin
            lo = range_from <= range_to ? range_from : range_to;
            hi = range_from <= range_to ? range_to : range_from;
            if ((prev_m < lo && m2 < lo) || (prev_m > hi && m2 > hi)) begin
               piece_open = 0;
            end else begin
               in1 = prev_m >= lo && prev_m <= hi;
               in2 = m2 >= lo && m2 <= hi;
               dm = m2 > prev_m ? m2 - prev_m : prev_m - m2;
               sx = prev_x; sy = prev_y; ex = x2; ey = y2; endc = 0;
               if (!in1) begin
                  sx = interpolate(prev_x, x2, prev_m < lo ? lo - prev_m : prev_m - hi, dm);
                  sy = interpolate(prev_y, y2, prev_m < lo ? lo - prev_m : prev_m - hi, dm);
               end
               if (!in2) begin
                  ex = interpolate(prev_x, x2, m2 > hi ? hi - prev_m : prev_m - lo, dm);
                  ey = interpolate(prev_y, y2, m2 > hi ? hi - prev_m : prev_m - lo, dm);
                  endc = 1;
               end
               if (!piece_open || !in1) push_point(sx, sy, 0);
               pend = endc || v.last_vertex;
               push_point(ex, ey, pend);
               piece_open = !pend;
            end
         end
         prev_x = x2; prev_y = y2; prev_m = m2;
         have_prev = 1;
         if (v.last_vertex) begin
            have_prev = 0;
            piece_open = 0;
         end
         if (expected_points.size() > n0)
            expected_points[expected_points.size() - 1].run_last = 1;
      endfunction

      function void check_point(point_type got);
         point_type want;
         if (expected_points.size() == 0) begin
            report($sformatf("unexpected point x=%0d y=%0d", got.out_x, got.out_y));
            return;
         end
         want = expected_points.pop_front();
         if (got.out_x !== want.out_x)
            report($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
         if (got.out_y !== want.out_y)
            report($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
         if (got.piece_end !== want.piece_end)
            report($sformatf("piece_end got %0b want %0b", got.piece_end, want.piece_end));
         if (got.run_last !== want.run_last)
            report($sformatf("run_last got %0b want %0b", got.run_last, want.run_last));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [mrlc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = mrlc_pkg::CSR_RANGE_FROM;
   logic [mrlc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   mrlc_if #(.PAYLOAD_WIDTH($bits(vertex_type))) req_ch ();
   mrlc_if #(.PAYLOAD_WIDTH($bits(point_type))) rsp_ch ();

   clip_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit recv_hold = 0;
   int quiet_cycles = 0;
   longint gen_lo, gen_hi;

   measure_range_line_clip u_top (
      .clock(clock), .reset(reset),
      .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
   end

   // Stall the result side at random, or hold it off entirely
   always @(posedge clock) begin
      rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // Note accepted vertices, check accepted points, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_vertex(vertex_type'(req_ch.payload));
         if (rsp_ch.valid && rsp_ch.ready) board.check_point(point_type'(rsp_ch.payload));
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // Write one range register, then drop the write enable and update the predictor
   task automatic write_csr(logic [mrlc_pkg::CSR_INDEX_WIDTH-1:0] idx, longint value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= 32'(value);
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
      if (idx == mrlc_pkg::CSR_RANGE_FROM) board.range_from = value;
      else board.range_to = value;
   endtask

   // Drop the offer, drain all points, then let a result-free item finish
   task automatic settle();
      req_ch.valid <= 0;
      while (board.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_range(longint from_v, longint to_v);
      settle();
      write_csr(mrlc_pkg::CSR_RANGE_FROM, from_v);
      write_csr(mrlc_pkg::CSR_RANGE_TO, to_v);
      gen_lo = from_v < to_v ? from_v : to_v;
      gen_hi = from_v < to_v ? to_v : from_v;
   endtask

   // Offer one vertex, hold until taken, then maybe go idle
   task automatic send_vertex(longint x, longint y, longint m, bit first, bit last);
      vertex_type v;
      v.vx = 32'(x); v.vy = 32'(y); v.vm = 32'(m);
      v.first_vertex = first; v.last_vertex = last;
      req_ch.valid <= 1;
      req_ch.payload <= v;
      do @(posedge clock); while (!req_ch.ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic longint clamp32(longint v);
      return v < INT_MIN ? INT_MIN : (v > INT_MAX ? INT_MAX : v);
   endfunction

   function automatic longint any32();
      return longint'($signed($urandom()));
   endfunction

   function automatic longint pick_coord();
      if ($urandom_range(9) == 0) return any32();
      return longint'($urandom_range(200000)) - 100000;
   endfunction

   // Measure near the range, sometimes exactly on a bound or anywhere in 32 bits
   function automatic longint pick_measure();
      longint w;
      case ($urandom_range(9))
         0: return gen_lo;
         1: return gen_hi;
         2: return any32();
         default: begin
            w = gen_hi - gen_lo + 1;
            if (w > 64'd1048576) w = 64'd1048576;
            return clamp32(gen_lo - w + longint'($urandom_range(32'(3 * w + gen_hi - gen_lo))));
         end
      endcase
   endfunction

   task automatic random_items(int count);
      int sent, len, k;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 15) begin
            send_vertex(any32(), any32(), any32(), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
            sent++;
         end else begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
               send_vertex(pick_coord(), pick_coord(), pick_measure(),
                           k == 0 && $urandom_range(9) != 0, k == len - 1);
            sent += len;
         end
      end
   endtask

   initial begin
      gen_lo = 0; gen_hi = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reversed range, crossings, touches, extremes
      set_range(100, -100);
      send_vertex(0, 0, -200, 1, 0);
      send_vertex(400, 400, 0, 0, 0);
      send_vertex(800, -400, 200, 0, 1);
      send_vertex(5, 5, 50, 1, 1);
      send_vertex(0, 0, -50, 1, 0);
      send_vertex(10, 10, -50, 0, 0);
      send_vertex(20, 30, 100, 0, 0);
      send_vertex(40, 60, 300, 0, 1);
      send_vertex(1, 1, 300, 1, 0);
      send_vertex(2, 2, 500, 0, 0);
      send_vertex(3, 3, -500, 0, 0);
      send_vertex(4, 4, -600, 0, 1);
      send_vertex(INT_MIN, INT_MAX, -100, 0, 0);
      send_vertex(INT_MAX, INT_MIN, 100, 0, 1);
      send_vertex(-1, -1, 0, 0, 0);
      send_vertex(INT_MIN, INT_MIN, INT_MIN, 0, 0);
      send_vertex(INT_MAX, INT_MAX, INT_MAX, 0, 0);
      send_vertex(7, 9, 3, 1, 0);
      send_vertex(0, 0, 2, 1, 0);
      send_vertex(3, 1, 4, 0, 1);

      set_range(-1000, 1000);
      random_items(130);

      set_range(5000, -5000);
      send_idle_pct = 51;
      random_items(120);

      set_range(INT_MIN, INT_MAX);
      send_idle_pct = 0;
      recv_stall_pct = 51;
      random_items(120);

      set_range(INT_MAX, INT_MIN);
      send_idle_pct = 22;
      recv_stall_pct = 22;
      random_items(60);
      set_range(0, 0);
      random_items(60);

      // Hold off the result side while vertices keep coming
      set_range(-300, 700);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            recv_hold = 1;
            repeat (3000) @(posedge clock);
            recv_hold = 0;
         end
      join_none
      random_items(120);

      settle();
      while (board.expected_points.size() != 0) begin
         board.report("expected point never arrived");
         void'(board.expected_points.pop_front());
      end
      if (board.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
design/mrlc_pkg.sv
design/mrlc_if.sv
design/mrlc_muldiv.sv
design/mrlc_front.sv
design/mrlc_queue.sv
design/mrlc_back.sv
design/measure_range_line_clip.sv
bench/testbench.sv
